[hw/rtl/line_segment_clipper_unit_defines.svh]
// ----------------------------------------------------------------------------
// Line segment clipper: assertion macros
// Concurrent assertion shorthands on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH
`define LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LSC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lsc assertion failed");
`define LSC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lsc assertion failed");
`else
`define LSC_ASSERT(name, prop)
`define LSC_ASSERT_NEXT(name, pre, post)
`endif

`endif

[hw/rtl/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// Line segment clipper package
// Outcode bits, register indexes and fixed sizes shared by the clipper files.
// ----------------------------------------------------------------------------
package lsc_pkg;

  typedef logic [3:0] oc_t;

  localparam oc_t OC_TOP    = 4'h1;
  localparam oc_t OC_BOTTOM = 4'h2;
  localparam oc_t OC_RIGHT  = 4'h4;
  localparam oc_t OC_LEFT   = 4'h8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

  localparam int X_MAX_RESET = 319;
  localparam int Y_MAX_RESET = 239;

  // clip steps before an undecided segment is dropped
  localparam int CLIP_LIMIT = 8;
  // quotient magnitude saturates at 2^QSAT_BITS
  localparam int QSAT_BITS  = 40;
  // multiplier digit width, bits of the first operand per cycle
  localparam int MUL_DIGIT  = 8;

endpackage

[hw/rtl/lsc_muldiv.sv]
// ----------------------------------------------------------------------------
// Line segment clipper: serial multiply-divide unit
// Computes trunc(a*b/c) with sign, digit-serial multiply then restoring divide.
// ----------------------------------------------------------------------------
`include "line_segment_clipper_unit_defines.svh"

module lsc_muldiv #(
  parameter int MW = 45
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MW-1:0]        a_i,
  input  logic [MW-1:0]        b_i,
  input  logic [MW-1:0]        c_i,
  input  logic                 neg_i,
  output logic                 done_o,
  output logic signed [MW-1:0] res_o
);
  import lsc_pkg::*;

  localparam int ND      = (MW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int AW      = ND * MUL_DIGIT;
  localparam int PW      = 2 * MW;
  localparam int HW      = PW - QSAT_BITS;
  localparam int QW      = QSAT_BITS + 1;
  localparam int PTW     = MW + MUL_DIGIT;
  localparam int CNT_MAX = (ND > QSAT_BITS) ? ND : QSAT_BITS;
  localparam int CNTW    = $clog2(CNT_MAX);

  localparam logic [2:0] MD_IDLE = 3'd0;
  localparam logic [2:0] MD_MUL  = 3'd1;
  localparam logic [2:0] MD_SAT  = 3'd2;
  localparam logic [2:0] MD_DIV  = 3'd3;
  localparam logic [2:0] MD_FIN  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [AW-1:0]        a_q, a_d;
  logic [MW-1:0]        b_q, b_d;
  logic [MW-1:0]        c_q, c_d;
  logic                 neg_q, neg_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [MW-1:0]        rem_q, rem_d;
  logic [QSAT_BITS-1:0] lo_q, lo_d;
  logic [QW-1:0]        q_q, q_d;
  logic signed [MW-1:0] res_q, res_d;

  logic [PTW-1:0]       part;
  logic [HW-1:0]        hi;
  logic [MW:0]          trial;
  logic [MW:0]          trial_diff;
  logic                 ge;
  logic [MW-1:0]        qx;

  always_comb begin
    part       = PTW'(b_q) * PTW'(a_q[AW-1 -: MUL_DIGIT]);
    hi         = prod_q[PW-1:QSAT_BITS];
    trial      = {rem_q, lo_q[QSAT_BITS-1]};
    trial_diff = trial - {1'b0, c_q};
    ge         = (trial >= {1'b0, c_q});
    qx         = MW'(q_q);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    q_d     = q_q;
    res_d   = res_q;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          a_d     = AW'(a_i);
          b_d     = b_i;
          c_d     = c_i;
          neg_d   = neg_i;
          prod_d  = '0;
          cnt_d   = CNTW'(ND - 1);
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_d = (prod_q << MUL_DIGIT) + PW'(part);
        a_d    = a_q << MUL_DIGIT;
        if (cnt_q == '0) begin
          state_d = MD_SAT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      MD_SAT: begin
        // a quotient at or above 2^QSAT_BITS shows in the high product bits
        if (c_q == '0) begin
          q_d     = '0;
          state_d = MD_FIN;
        end else if (hi >= HW'(c_q)) begin
          q_d     = QW'(1) << QSAT_BITS;
          state_d = MD_FIN;
        end else begin
          rem_d   = hi[MW-1:0];
          lo_d    = prod_q[QSAT_BITS-1:0];
          q_d     = '0;
          cnt_d   = CNTW'(QSAT_BITS - 1);
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_d = ge ? trial_diff[MW-1:0] : trial[MW-1:0];
        q_d   = {q_q[QW-2:0], ge};
        lo_d  = lo_q << 1;
        if (cnt_q == '0) begin
          state_d = MD_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      MD_FIN: begin
        res_d   = neg_q ? -$signed(qx) : $signed(qx);
        done_d  = 1'b1;
        state_d = MD_IDLE;
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    q_q    <= q_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `LSC_ASSERT(a_md_start_idle, !start_i || state_q == MD_IDLE)
  `LSC_ASSERT_NEXT(a_md_done_pulse, done_q, !done_q)
  `LSC_ASSERT(a_md_rem_below_div, state_q != MD_DIV || rem_q < c_q)

endmodule

[hw/rtl/line_segment_clipper_unit.sv]
// Each clip step: edge check, multiply, saturation check, divide when not saturated,
//   result and handoff; at most 4 steps.
// Throughput: one segment at a time; the next can be taken once the result has loaded.
// An inverted window stops after 8 steps and rejects the segment.
// Reset: asynchronous, active low; control cleared, window set to 0,0,319,239.
// ----------------------------------------------------------------------------
// Line segment clipper unit
// Cohen-Sutherland clipping of one segment against the configured window.
// ----------------------------------------------------------------------------
`include "line_segment_clipper_unit_defines.svh"

module line_segment_clipper_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_BITS-1:0]   start_x_i,
  input  logic signed [COORD_BITS-1:0]   start_y_i,
  input  logic signed [COORD_BITS-1:0]   end_x_i,
  input  logic signed [COORD_BITS-1:0]   end_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o,
  output logic signed [COORD_BITS-1:0]   clip_start_x_o,
  output logic signed [COORD_BITS-1:0]   clip_start_y_o,
  output logic signed [COORD_BITS-1:0]   clip_end_x_o,
  output logic signed [COORD_BITS-1:0]   clip_end_y_o
);
  import lsc_pkg::*;

  // wide enough for CLIP_LIMIT saturated quotient additions
  localparam int CW = ((COORD_BITS > QSAT_BITS) ? COORD_BITS : QSAT_BITS) + 5;
  localparam int NW = $clog2(CLIP_LIMIT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  function automatic logic signed [CW-1:0] widen(input logic signed [COORD_BITS-1:0] v);
    return {{(CW - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic oc_t outcode(input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] y,
                                  input logic signed [CW-1:0] xl,
                                  input logic signed [CW-1:0] yl,
                                  input logic signed [CW-1:0] xh,
                                  input logic signed [CW-1:0] yh);
    oc_t c;
    c = '0;
    if (y > yh) c = c | OC_TOP;
    else if (y < yl) c = c | OC_BOTTOM;
    if (x > xh) c = c | OC_RIGHT;
    else if (x < xl) c = c | OC_LEFT;
    return c;
  endfunction

  function automatic logic [CW-1:0] magn(input logic signed [CW:0] v);
    logic signed [CW:0] n;
    n = v[CW] ? -v : v;
    return n[CW-1:0];
  endfunction

  logic signed [COORD_BITS-1:0] x_min_q, y_min_q, x_max_q, y_max_q;
  logic signed [CW-1:0]         xl_w, yl_w, xh_w, yh_w;

  logic [1:0]           state_q, state_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 acc_q, acc_d;
  logic                 upd_start_q, upd_start_d;
  logic                 vert_q, vert_d;
  logic signed [CW-1:0] bound_q, bound_d;
  logic signed [CW-1:0] sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;

  logic                         out_valid_q, out_valid_d;
  logic                         out_acc_q, out_acc_d;
  logic signed [COORD_BITS-1:0] out_sx_q, out_sx_d, out_sy_q, out_sy_d;
  logic signed [COORD_BITS-1:0] out_ex_q, out_ex_d, out_ey_q, out_ey_d;

  oc_t                  cs, ce, code;
  logic                 vert, top_sel, right_sel;
  logic signed [CW-1:0] bound_w;
  logic signed [CW:0]   dx, dy, d_a, d_b, d_c;
  logic [CW-1:0]        md_a, md_b, md_c;
  logic                 md_neg;
  logic                 md_start;
  logic                 md_done;
  logic signed [CW-1:0] md_res;
  logic signed [CW-1:0] new_other;

  assign xl_w = widen(x_min_q);
  assign yl_w = widen(y_min_q);
  assign xh_w = widen(x_max_q);
  assign yh_w = widen(y_max_q);

  // edge selection and operands for the next clip step
  always_comb begin
    cs        = outcode(sx_q, sy_q, xl_w, yl_w, xh_w, yh_w);
    ce        = outcode(ex_q, ey_q, xl_w, yl_w, xh_w, yh_w);
    code      = (cs != '0) ? cs : ce;
    top_sel   = (code & OC_TOP) != '0;
    vert      = top_sel || ((code & OC_BOTTOM) != '0);
    right_sel = (code & OC_RIGHT) != '0;
    bound_w   = vert ? (top_sel ? yh_w : yl_w) : (right_sel ? xh_w : xl_w);
    dx        = {ex_q[CW-1], ex_q} - {sx_q[CW-1], sx_q};
    dy        = {ey_q[CW-1], ey_q} - {sy_q[CW-1], sy_q};
    d_a       = vert ? dx : dy;
    d_b       = vert ? ({bound_w[CW-1], bound_w} - {sy_q[CW-1], sy_q})
                     : ({bound_w[CW-1], bound_w} - {sx_q[CW-1], sx_q});
    d_c       = vert ? dy : dx;
    md_a      = magn(d_a);
    md_b      = magn(d_b);
    md_c      = magn(d_c);
    md_neg    = d_a[CW] ^ d_b[CW] ^ d_c[CW];
    new_other = (vert_q ? sx_q : sy_q) + md_res;
  end

  lsc_muldiv #(
    .MW (CW)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .c_i     (md_c),
    .neg_i   (md_neg),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    acc_d       = acc_q;
    upd_start_d = upd_start_q;
    vert_d      = vert_q;
    bound_d     = bound_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    md_start    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_acc_d   = out_acc_q;
    out_sx_d    = out_sx_q;
    out_sy_d    = out_sy_q;
    out_ex_d    = out_ex_q;
    out_ey_d    = out_ey_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sx_d    = widen(start_x_i);
          sy_d    = widen(start_y_i);
          ex_d    = widen(end_x_i);
          ey_d    = widen(end_y_i);
          n_d     = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((cs | ce) == '0) begin
          acc_d   = 1'b1;
          state_d = ST_FIN;
        end else if ((cs & ce) != '0 || n_q == NW'(CLIP_LIMIT)) begin
          acc_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          md_start    = 1'b1;
          upd_start_d = (cs != '0);
          vert_d      = vert;
          bound_d     = bound_w;
          state_d     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          if (upd_start_q) begin
            sx_d = vert_q ? new_other : bound_q;
            sy_d = vert_q ? bound_q : new_other;
          end else begin
            ex_d = vert_q ? new_other : bound_q;
            ey_d = vert_q ? bound_q : new_other;
          end
          n_d     = n_q + 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          out_sx_d    = acc_q ? sx_q[COORD_BITS-1:0] : '0;
          out_sy_d    = acc_q ? sy_q[COORD_BITS-1:0] : '0;
          out_ex_d    = acc_q ? ex_q[COORD_BITS-1:0] : '0;
          out_ey_d    = acc_q ? ey_q[COORD_BITS-1:0] : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      x_min_q     <= '0;
      y_min_q     <= '0;
      x_max_q     <= COORD_BITS'(X_MAX_RESET);
      y_max_q     <= COORD_BITS'(Y_MAX_RESET);
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_X_MIN: x_min_q <= cfg_wdata_i;
          REG_Y_MIN: y_min_q <= cfg_wdata_i;
          REG_X_MAX: x_max_q <= cfg_wdata_i;
          REG_Y_MAX: y_max_q <= cfg_wdata_i;
          default:   x_min_q <= x_min_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    upd_start_q <= upd_start_d;
    vert_q      <= vert_d;
    bound_q     <= bound_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    ex_q        <= ex_d;
    ey_q        <= ey_d;
    out_acc_q   <= out_acc_d;
    out_sx_q    <= out_sx_d;
    out_sy_q    <= out_sy_d;
    out_ex_q    <= out_ex_d;
    out_ey_q    <= out_ey_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign clip_start_x_o = out_sx_q;
  assign clip_start_y_o = out_sy_q;
  assign clip_end_x_o   = out_ex_q;
  assign clip_end_y_o   = out_ey_q;

  `LSC_ASSERT(a_done_in_wait, !md_done || state_q == ST_WAIT)
  `LSC_ASSERT(a_step_bound, n_q <= NW'(CLIP_LIMIT))
  `LSC_ASSERT(a_acc_inside, !(out_valid_o && accepted_o) ||
      (clip_start_x_o >= x_min_q && clip_start_x_o <= x_max_q &&
       clip_start_y_o >= y_min_q && clip_start_y_o <= y_max_q &&
       clip_end_x_o >= x_min_q && clip_end_x_o <= x_max_q &&
       clip_end_y_o >= y_min_q && clip_end_y_o <= y_max_q))
  `LSC_ASSERT(a_rej_zero, !(out_valid_o && !accepted_o) ||
      (clip_start_x_o == '0 && clip_start_y_o == '0 &&
       clip_end_x_o == '0 && clip_end_y_o == '0))

endmodule
